// File: hw/rtl/pif_pkg.sv
`default_nettype none

package pif_pkg;

    // Default sizing
    localparam int DEF_MAX_WIDTH     = 64;
    localparam int DEF_MAX_PRECISION = 40;
    localparam int DEF_VALUE_BITS    = 64;

    // Digit store: enough nibbles for 64 bits in octal (22) or decimal (20)
    localparam int DIGITS = 22;
    localparam int IDX_W  = $clog2(DIGITS);

    // Base select codes
    localparam logic [1:0] BASE_DEC    = 2'd0;
    localparam logic [1:0] BASE_OCT    = 2'd1;
    localparam logic [1:0] BASE_HEX_LO = 2'd2;
    localparam logic [1:0] BASE_HEX_UP = 2'd3;

    // Flag bit positions
    localparam int FL_LEFT  = 0;
    localparam int FL_PLUS  = 1;
    localparam int FL_SPACE = 2;
    localparam int FL_ALT   = 3;
    localparam int FL_ZERO  = 4;
    localparam int FL_PREC  = 5;

    // ASCII codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_X_LO  = 8'h78;

    typedef struct packed {
        logic [63:0] value;
        logic        is_signed;
        logic [1:0]  base_sel;
        logic [5:0]  flag_bits;
        logic [6:0]  width;
        logic [5:0]  precision;
    } t_req;

    typedef struct packed {
        logic [7:0] character;
        logic       is_last;
        logic       empty_res;
    } t_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIGITS,
        ST_PLAN,
        ST_EMIT,
        ST_EMPTY
    } t_state;

    typedef enum logic [1:0] {
        DG_IDLE,
        DG_DABBLE,
        DG_NORM
    } t_dig_state;

    // Top level to digit unit
    typedef struct packed {
        logic       start;
        logic [1:0] base_sel;
    } t_dig_cmd;

    // Digit unit to top level
    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] cnt;
    } t_dig_sts;

    // One digit value to its ASCII character
    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] ch;
        if (d < 4'd10) begin
            ch = CH_ZERO + {4'b0000, d};
        end else begin
            ch = (upper ? CH_A_UP : CH_A_LO) + {4'b0000, d} - 8'd10;
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/pif_digits.sv
`default_nettype none

module pif_digits #(
    parameter int VALUE_BITS = pif_pkg::DEF_VALUE_BITS
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire pif_pkg::t_dig_cmd        i_cmd,
    input  wire logic [VALUE_BITS-1:0]    i_mag,
    input  wire logic [pif_pkg::IDX_W-1:0] i_rd_idx,
    output pif_pkg::t_dig_sts             o_sts,
    output logic [3:0]                    o_rd_digit
);
    import pif_pkg::*;

    localparam int STEP_W   = $clog2(VALUE_BITS + 1);
    localparam int PAD_BITS = DIGITS * 4;

    t_dig_state              r_state, n_state;
    logic [3:0]              r_dig [DIGITS];
    logic [3:0]              n_dig [DIGITS];
    logic [VALUE_BITS-1:0]   r_bin, n_bin;
    logic [STEP_W-1:0]       r_step, n_step;
    logic [IDX_W-1:0]        r_cnt, n_cnt;

    logic [PAD_BITS-1:0]     mag_pad;
    logic [3:0]              adj [DIGITS];
    logic [IDX_W-1:0]        rd_idx;
    logic [3:0]              rd_digit;
    logic                    stop;

    assign mag_pad = PAD_BITS'(i_mag);

    // Single read port: normalize scan or emitter
    assign rd_idx   = (r_state == DG_NORM) ? (r_cnt - IDX_W'(1)) : i_rd_idx;
    assign rd_digit = (rd_idx < IDX_W'(DIGITS)) ? r_dig[rd_idx] : 4'd0;
    assign stop     = (r_cnt == IDX_W'(1)) || (rd_digit != 4'd0);

    assign o_rd_digit = rd_digit;
    assign o_sts.done = (r_state == DG_NORM) && stop;
    assign o_sts.cnt  = r_cnt;

    // Add-3 correction on every BCD digit
    always_comb begin
        for (int j = 0; j < DIGITS; j++) begin
            adj[j] = (r_dig[j] >= 4'd5) ? (r_dig[j] + 4'd3) : r_dig[j];
        end
    end

    // Sequencer: load, double dabble (decimal only), strip leading zeros
    always_comb begin
        n_state = r_state;
        n_dig   = r_dig;
        n_bin   = r_bin;
        n_step  = r_step;
        n_cnt   = r_cnt;
        case (r_state)
            DG_IDLE: begin
                if (i_cmd.start) begin
                    if (i_cmd.base_sel == BASE_DEC) begin
                        for (int j = 0; j < DIGITS; j++) begin
                            n_dig[j] = 4'd0;
                        end
                        n_bin   = i_mag;
                        n_step  = STEP_W'(VALUE_BITS);
                        n_state = DG_DABBLE;
                    end else begin
                        for (int j = 0; j < DIGITS; j++) begin
                            if (i_cmd.base_sel == BASE_OCT) begin
                                n_dig[j] = {1'b0, mag_pad[3*j +: 3]};
                            end else begin
                                n_dig[j] = mag_pad[4*j +: 4];
                            end
                        end
                        n_cnt   = IDX_W'(DIGITS);
                        n_state = DG_NORM;
                    end
                end
            end
            DG_DABBLE: begin
                n_dig[0] = {adj[0][2:0], r_bin[VALUE_BITS-1]};
                for (int j = 1; j < DIGITS; j++) begin
                    n_dig[j] = {adj[j][2:0], adj[j-1][3]};
                end
                n_bin  = r_bin << 1;
                n_step = r_step - STEP_W'(1);
                if (r_step == STEP_W'(1)) begin
                    n_cnt   = IDX_W'(DIGITS);
                    n_state = DG_NORM;
                end
            end
            DG_NORM: begin
                if (stop) begin
                    n_state = DG_IDLE;
                end else begin
                    n_cnt = r_cnt - IDX_W'(1);
                end
            end
            default: begin
                n_state = DG_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DG_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dig  <= n_dig;
        r_bin  <= n_bin;
        r_step <= n_step;
        r_cnt  <= n_cnt;
    end

    // Checks
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |-> (r_state == DG_IDLE))
        else $error("digit unit started while busy");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == DG_NORM) |-> (r_cnt >= IDX_W'(1) && r_cnt <= IDX_W'(DIGITS)))
        else $error("digit count out of range");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_sts.done |=> (r_state == DG_IDLE))
        else $error("digit unit did not return to idle");

    a_step_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == DG_DABBLE) |-> (r_step != '0))
        else $error("dabble step counter underflow");

endmodule

`default_nettype wire

// File: hw/rtl/printf_integer_formatter_unit.sv
`default_nettype none

// Integer conversion formatter (printf style %d/%u/%o/%x/%X).
// Request channel: i_req_valid / o_req_ready with i_req (value, is_signed,
// base_sel, flag_bits, width, precision). Response channel: o_rsp_valid /
// i_rsp_ready with o_rsp (character, is_last, empty_res), one ASCII
// character per transfer, left to right, is_last on the final one. A
// conversion with no text gives one transfer with empty_res and is_last.
// Sequence: a load state, then the digit unit: hex/octal only strip
// leading zeros; decimal first runs VALUE_BITS double-dabble shifts (one
// bit per cycle), then strips leading zeros. A planning state follows,
// then one character per cycle while the receiver is ready, up to 64
// characters per conversion.
// o_req_ready is high only while no conversion is in progress; the next
// request is taken while the final character still waits in the output
// register. A stalled receiver holds the output register and the
// sequencer waits. Reset (synchronous, active low) returns to idle with
// no response pending.
module printf_integer_formatter_unit #(
    parameter int MAX_WIDTH     = pif_pkg::DEF_MAX_WIDTH,
    parameter int MAX_PRECISION = pif_pkg::DEF_MAX_PRECISION,
    parameter int VALUE_BITS    = pif_pkg::DEF_VALUE_BITS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_req_valid,
    output logic               o_req_ready,
    input  wire pif_pkg::t_req i_req,
    output logic               o_rsp_valid,
    input  wire logic          i_rsp_ready,
    output pif_pkg::t_rsp      o_rsp
);
    import pif_pkg::*;

    t_state                r_state, n_state;
    logic [VALUE_BITS-1:0] r_mag, n_mag;
    logic                  r_neg, n_neg;
    logic                  r_sgn, n_sgn;
    logic [1:0]            r_base, n_base;
    logic [5:0]            r_fl, n_fl;
    logic [6:0]            r_w, n_w;
    logic [5:0]            r_p, n_p;
    logic [IDX_W-1:0]      r_cnt, n_cnt;
    logic [6:0]            r_lspc, n_lspc;
    logic [6:0]            r_rspc, n_rspc;
    logic [6:0]            r_zeros, n_zeros;
    logic                  r_sign_pend, n_sign_pend;
    logic [7:0]            r_sign_ch, n_sign_ch;
    logic                  r_pfx0, n_pfx0;
    logic                  r_pfxx, n_pfxx;
    logic [6:0]            r_left, n_left;
    logic                  r_ovalid;
    t_rsp                  r_orsp;

    logic                  emit;
    t_rsp                  n_rsp;
    logic                  out_free;
    logic                  req_xfer;

    logic [VALUE_BITS-1:0] in_v, in_vneg;
    logic                  in_neg;

    t_dig_cmd              dig_cmd;
    t_dig_sts              dig_sts;
    logic [3:0]            dig_digit;

    logic                  pl_nz, pl_hex_pfx, pl_oct_alt, pl_sign_on, pl_prec_pad;
    logic                  pl_special, pl_fill;
    logic [7:0]            pl_sign_ch;
    logic [6:0]            pl_zeros0, pl_full, pl_pad, pl_spc;
    logic [7:0]            emit_sum;

    assign o_req_ready = (r_state == ST_IDLE);
    assign req_xfer    = i_req_valid && o_req_ready;
    assign out_free    = !r_ovalid || i_rsp_ready;
    assign o_rsp_valid = r_ovalid;
    assign o_rsp       = r_orsp;

    // Magnitude of the incoming value
    assign in_v    = i_req.value[VALUE_BITS-1:0];
    assign in_vneg = ~in_v + {{(VALUE_BITS-1){1'b0}}, 1'b1};
    assign in_neg  = i_req.is_signed && in_v[VALUE_BITS-1];

    // Digit extraction unit
    assign dig_cmd.start    = (r_state == ST_LOAD);
    assign dig_cmd.base_sel = r_base;

    pif_digits #(
        .VALUE_BITS (VALUE_BITS)
    ) u_digits (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dig_cmd),
        .i_mag      (r_mag),
        .i_rd_idx   (r_cnt - IDX_W'(1)),
        .o_sts      (dig_sts),
        .o_rd_digit (dig_digit)
    );

    // Layout planning from digit count and flags
    always_comb begin
        pl_nz       = (r_mag != '0);
        pl_hex_pfx  = r_fl[FL_ALT] && pl_nz && r_base[1];
        pl_oct_alt  = r_fl[FL_ALT] && pl_nz && (r_base == BASE_OCT);
        pl_special  = r_fl[FL_PREC] && (r_p == 6'd0) && !pl_nz;
        pl_sign_on  = 1'b0;
        pl_sign_ch  = CH_NUL;
        if (r_sgn) begin
            if (r_neg) begin
                pl_sign_on = 1'b1;
                pl_sign_ch = CH_MINUS;
            end else if (r_fl[FL_PLUS]) begin
                pl_sign_on = 1'b1;
                pl_sign_ch = CH_PLUS;
            end else if (r_fl[FL_SPACE]) begin
                pl_sign_on = 1'b1;
                pl_sign_ch = CH_SPACE;
            end
        end
        pl_prec_pad = r_fl[FL_PREC] && (6'(r_cnt) < r_p);
        pl_zeros0   = pl_prec_pad ? 7'(r_p - 6'(r_cnt)) : 7'(pl_oct_alt);
        pl_full     = pl_zeros0 + {5'd0, pl_hex_pfx, 1'b0} + 7'(pl_sign_on) + 7'(r_cnt);
        pl_fill     = (r_w > pl_full);
        pl_pad      = r_w - pl_full;
        pl_spc      = (pl_fill && !r_fl[FL_ZERO]) ? pl_pad : 7'd0;
    end

    // Sequencer and character selection
    always_comb begin
        n_state     = r_state;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_sgn       = r_sgn;
        n_base      = r_base;
        n_fl        = r_fl;
        n_w         = r_w;
        n_p         = r_p;
        n_cnt       = r_cnt;
        n_lspc      = r_lspc;
        n_rspc      = r_rspc;
        n_zeros     = r_zeros;
        n_sign_pend = r_sign_pend;
        n_sign_ch   = r_sign_ch;
        n_pfx0      = r_pfx0;
        n_pfxx      = r_pfxx;
        n_left      = r_left;
        emit        = 1'b0;
        n_rsp       = '0;
        case (r_state)
            ST_IDLE: begin
                if (req_xfer) begin
                    n_mag   = in_neg ? in_vneg : in_v;
                    n_neg   = in_neg;
                    n_sgn   = i_req.is_signed;
                    n_base  = i_req.base_sel;
                    n_fl    = i_req.flag_bits;
                    n_w     = (i_req.width > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : i_req.width;
                    n_p     = (i_req.precision > 6'(MAX_PRECISION)) ?
                              6'(MAX_PRECISION) : i_req.precision;
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_state = ST_DIGITS;
            end
            ST_DIGITS: begin
                if (dig_sts.done) begin
                    n_cnt   = dig_sts.cnt;
                    n_state = ST_PLAN;
                end
            end
            ST_PLAN: begin
                if (pl_special) begin
                    n_lspc      = r_w;
                    n_rspc      = 7'd0;
                    n_zeros     = 7'd0;
                    n_cnt       = '0;
                    n_sign_pend = 1'b0;
                    n_pfx0      = 1'b0;
                    n_pfxx      = 1'b0;
                    n_left      = r_w;
                    n_state     = (r_w == 7'd0) ? ST_EMPTY : ST_EMIT;
                end else begin
                    n_zeros     = pl_zeros0 +
                                  ((pl_fill && r_fl[FL_ZERO]) ? pl_pad : 7'd0);
                    n_lspc      = r_fl[FL_LEFT] ? 7'd0 : pl_spc;
                    n_rspc      = r_fl[FL_LEFT] ? pl_spc : 7'd0;
                    n_sign_pend = pl_sign_on;
                    n_sign_ch   = pl_sign_ch;
                    n_pfx0      = pl_hex_pfx;
                    n_pfxx      = pl_hex_pfx;
                    n_left      = pl_fill ? r_w : pl_full;
                    n_state     = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    emit          = 1'b1;
                    n_rsp.is_last = (r_left == 7'd1);
                    n_left        = r_left - 7'd1;
                    if (r_lspc != 7'd0) begin
                        n_rsp.character = CH_SPACE;
                        n_lspc          = r_lspc - 7'd1;
                    end else if (r_sign_pend) begin
                        n_rsp.character = r_sign_ch;
                        n_sign_pend     = 1'b0;
                    end else if (r_pfx0) begin
                        n_rsp.character = CH_ZERO;
                        n_pfx0          = 1'b0;
                    end else if (r_pfxx) begin
                        n_rsp.character = (r_base == BASE_HEX_UP) ? CH_X_UP : CH_X_LO;
                        n_pfxx          = 1'b0;
                    end else if (r_zeros != 7'd0) begin
                        n_rsp.character = CH_ZERO;
                        n_zeros         = r_zeros - 7'd1;
                    end else if (r_cnt != '0) begin
                        n_rsp.character = digit_char(dig_digit, r_base == BASE_HEX_UP);
                        n_cnt           = r_cnt - IDX_W'(1);
                    end else begin
                        n_rsp.character = CH_SPACE;
                        n_rspc          = r_rspc - 7'd1;
                    end
                    if (r_left == 7'd1) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_EMPTY: begin
                if (out_free) begin
                    emit            = 1'b1;
                    n_rsp.character = CH_NUL;
                    n_rsp.is_last   = 1'b1;
                    n_rsp.empty_res = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_free) begin
                r_ovalid <= emit;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_mag       <= n_mag;
        r_neg       <= n_neg;
        r_sgn       <= n_sgn;
        r_base      <= n_base;
        r_fl        <= n_fl;
        r_w         <= n_w;
        r_p         <= n_p;
        r_cnt       <= n_cnt;
        r_lspc      <= n_lspc;
        r_rspc      <= n_rspc;
        r_zeros     <= n_zeros;
        r_sign_pend <= n_sign_pend;
        r_sign_ch   <= n_sign_ch;
        r_pfx0      <= n_pfx0;
        r_pfxx      <= n_pfxx;
        r_left      <= n_left;
        if (emit) begin
            r_orsp <= n_rsp;
        end
    end

    // Checks
    assign emit_sum = 8'(r_lspc) + 8'(r_rspc) + 8'(r_zeros) + 8'(r_cnt) +
                      8'(r_sign_pend) + 8'(r_pfx0) + 8'(r_pfxx);

    a_left_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (emit_sum == 8'(r_left)))
        else $error("remaining count disagrees with pending characters");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_orsp.empty_res) |-> (r_orsp.is_last && r_orsp.character == CH_NUL))
        else $error("empty result without last marker");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && n_rsp.is_last) |=> (r_state == ST_IDLE && r_ovalid))
        else $error("sequencer did not finish after last character");

endmodule

`default_nettype wire

// File: tb/tb_printf_integer_formatter_unit.sv
module tb_printf_integer_formatter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import pif_pkg::*;

    localparam int MAX_W      = DEF_MAX_WIDTH;
    localparam int MAX_P      = DEF_MAX_PRECISION;
    localparam int LONG_HOLD  = 400;
    localparam int N_RANDOM   = 335;
    localparam int QUIET_TAIL = 60;

    // Flag masks built from the package bit positions
    localparam logic [5:0] F_LEFT  = 6'd1 << FL_LEFT;
    localparam logic [5:0] F_PLUS  = 6'd1 << FL_PLUS;
    localparam logic [5:0] F_SPACE = 6'd1 << FL_SPACE;
    localparam logic [5:0] F_ALT   = 6'd1 << FL_ALT;
    localparam logic [5:0] F_ZERO  = 6'd1 << FL_ZERO;
    localparam logic [5:0] F_PREC  = 6'd1 << FL_PREC;

    logic i_clk;
    logic i_rst_n     = 1'b0;
    logic i_req_valid = 1'b0;
    logic o_req_ready;
    t_req i_req       = '0;
    logic o_rsp_valid;
    logic i_rsp_ready = 1'b0;
    t_rsp o_rsp;

    t_req request_q[$];
    t_rsp expected_chars[$];

    int unsigned n_queued   = 0;
    int unsigned n_accepted = 0;
    int unsigned err_cnt    = 0;
    logic        req_taken  = 1'b0;
    logic        quiet      = 1'b0;
    logic        want_hold  = 1'b0;
    logic        hold_done  = 1'b0;
    int unsigned hold_cycles = 0;
    int unsigned send_gap   = 0;
    int unsigned stall_left = 0;

    printf_integer_formatter_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Expected text of one conversion, pushed one character per transfer
    task automatic format_conversion(input t_req r);
        logic [63:0]  mag;
        logic [63:0]  rest;
        logic [3:0]   digs[DIGITS];
        logic [7:0]   txt[$];
        logic [7:0]   sign_ch;
        logic [3:0]   d;
        logic         neg;
        logic         upper;
        int unsigned  radix;
        int unsigned  fw;
        int unsigned  prec;
        int unsigned  ndig;
        int unsigned  nzero;
        int unsigned  npre;
        int unsigned  nspace;
        int unsigned  full;
        t_rsp         c;

        fw    = (r.width > MAX_W) ? MAX_W : r.width;
        prec  = (r.precision > MAX_P) ? MAX_P : r.precision;
        neg   = r.is_signed && r.value[63];
        mag   = neg ? (~r.value + 64'd1) : r.value;
        upper = (r.base_sel == BASE_HEX_UP);
        case (r.base_sel)
            BASE_DEC: radix = 10;
            BASE_OCT: radix = 8;
            default:  radix = 16;
        endcase

        if (r.flag_bits[FL_PREC] && prec == 0 && mag == 0) begin
            // no digits at all: only the field width in spaces
            if (fw == 0) begin
                c.character = CH_NUL;
                c.is_last   = 1'b1;
                c.empty_res = 1'b1;
                expected_chars.push_back(c);
            end else begin
                repeat (fw) txt.push_back(CH_SPACE);
            end
        end else begin
            ndig = 0;
            rest = mag;
            do begin
                digs[ndig] = 4'(rest % radix);
                rest = rest / radix;
                ndig++;
            end while (rest != 0 && ndig < DIGITS);

            nzero  = 0;
            npre   = 0;
            nspace = 0;
            sign_ch = CH_NUL;
            if (r.flag_bits[FL_ALT] && mag != 0) begin
                if (radix == 16) npre += 2;
                if (radix == 8) nzero = 1;
            end
            if (r.is_signed) begin
                if (neg) sign_ch = CH_MINUS;
                else if (r.flag_bits[FL_PLUS]) sign_ch = CH_PLUS;
                else if (r.flag_bits[FL_SPACE]) sign_ch = CH_SPACE;
                if (sign_ch != CH_NUL) npre += 1;
            end
            // precision count replaces the octal alternate-form zero
            if (r.flag_bits[FL_PREC] && ndig < prec) nzero = prec - ndig;
            full = nzero + npre + ndig;
            if (fw > full) begin
                if (r.flag_bits[FL_ZERO]) nzero += fw - full;
                else nspace = fw - full;
            end

            if (!r.flag_bits[FL_LEFT]) repeat (nspace) txt.push_back(CH_SPACE);
            if (sign_ch != CH_NUL) txt.push_back(sign_ch);
            if (r.flag_bits[FL_ALT] && mag != 0 && radix == 16) begin
                txt.push_back(CH_ZERO);
                txt.push_back(upper ? CH_X_UP : CH_X_LO);
            end
            repeat (nzero) txt.push_back(CH_ZERO);
            for (int i = ndig; i > 0; i--) begin
                d = digs[i - 1];
                if (d < 4'd10) txt.push_back(CH_ZERO + 8'(d));
                else txt.push_back((upper ? CH_A_UP : CH_A_LO) + 8'(d) - 8'd10);
            end
            if (r.flag_bits[FL_LEFT]) repeat (nspace) txt.push_back(CH_SPACE);
        end

        foreach (txt[i]) begin
            c.character = txt[i];
            c.is_last   = (i == txt.size() - 1);
            c.empty_res = 1'b0;
            expected_chars.push_back(c);
        end
    endtask

    task automatic queue_conv(input logic [63:0] v, input logic s, input logic [1:0] b,
                              input logic [5:0] f, input logic [6:0] w, input logic [5:0] p);
        t_req r;
        r.value     = v;
        r.is_signed = s;
        r.base_sel  = b;
        r.flag_bits = f;
        r.width     = w;
        r.precision = p;
        request_q.push_back(r);
        n_queued++;
    endtask

    // Mostly small widths and precisions, with a spread of value classes
    function automatic t_req random_conv();
        t_req r;
        int unsigned kind;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2: r.value = 64'($urandom_range(0, 999));
            3, 4, 5: r.value = {$urandom, $urandom};
            6:       r.value = '0;
            7:       r.value = -64'($urandom_range(1, 5000));
            8: begin
                case ($urandom_range(0, 2))
                    0:       r.value = '1;
                    1:       r.value = 64'h8000_0000_0000_0000;
                    default: r.value = 64'h7FFF_FFFF_FFFF_FFFF;
                endcase
            end
            default: r.value = 64'd1 << $urandom_range(0, 63);
        endcase
        r.is_signed = 1'($urandom);
        r.base_sel  = 2'($urandom);
        r.flag_bits = 6'($urandom);
        r.precision = ($urandom_range(0, 4) != 0) ? 6'($urandom_range(0, 12))
                                                   : 6'($urandom_range(0, 63));
        r.width     = ($urandom_range(0, 4) != 0) ? 7'($urandom_range(0, 24))
                                                   : 7'($urandom_range(0, 127));
        return r;
    endfunction

    // Result checker and request predictor at the rising edge
    always @(posedge i_clk) begin : mon_blk
        t_rsp want;
        req_taken <= i_rst_n && i_req_valid && o_req_ready;
        if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
            if (expected_chars.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected transfer, expected none, actual %h", $time, o_rsp);
            end else begin
                want = expected_chars.pop_front();
                if (!want.empty_res && o_rsp.character !== want.character) begin
                    err_cnt++;
                    $display("%0t: character mismatch, expected %h actual %h",
                             $time, want.character, o_rsp.character);
                end
                if (o_rsp.is_last !== want.is_last) begin
                    err_cnt++;
                    $display("%0t: is_last mismatch, expected %b actual %b",
                             $time, want.is_last, o_rsp.is_last);
                end
                if (o_rsp.empty_res !== want.empty_res) begin
                    err_cnt++;
                    $display("%0t: empty_res mismatch, expected %b actual %b",
                             $time, want.empty_res, o_rsp.empty_res);
                end
            end
        end
        if (i_rst_n && i_req_valid && o_req_ready) begin
            format_conversion(i_req);
            n_accepted++;
        end
    end

    // Request driver: holds each request until its transfer
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_req_valid <= 1'b0;
        end else if (!i_req_valid || req_taken) begin
            if (send_gap > 0) begin
                send_gap    <= send_gap - 1;
                i_req_valid <= 1'b0;
            end else if (request_q.size() == 0) begin
                i_req_valid <= 1'b0;
            end else if (!quiet && ((n_accepted / 40) % 3) != 2
                         && $urandom_range(0, 3) == 0) begin
                send_gap    <= $urandom_range(0, 10);
                i_req_valid <= 1'b0;
            end else begin
                i_req       <= request_q.pop_front();
                i_req_valid <= 1'b1;
            end
        end
    end

    // Response side back-pressure, with one long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_rsp_ready <= 1'b0;
        end else if (want_hold && !hold_done) begin
            i_rsp_ready <= 1'b0;
            hold_cycles <= hold_cycles + 1;
            if (hold_cycles == LONG_HOLD - 1) hold_done <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_rsp_ready <= 1'b0;
        end else if (!quiet && ((n_accepted / 25) % 4) != 3
                     && $urandom_range(0, 4) == 0) begin
            stall_left  <= $urandom_range(0, 10);
            i_rsp_ready <= 1'b0;
        end else begin
            i_rsp_ready <= 1'b1;
        end
    end

    // Stimulus sequence and end of run
    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners
        queue_conv(64'd0, 1'b0, BASE_DEC, 6'd0, 7'd0, 6'd0);
        queue_conv('1, 1'b0, BASE_DEC, 6'd0, 7'd0, 6'd0);
        queue_conv('1, 1'b1, BASE_DEC, 6'd0, 7'd0, 6'd0);
        queue_conv(64'h8000_0000_0000_0000, 1'b1, BASE_DEC, 6'd0, 7'd0, 6'd0);
        queue_conv(64'h8000_0000_0000_0000, 1'b0, BASE_OCT, F_ALT, 7'd0, 6'd0);
        queue_conv('1, 1'b0, BASE_OCT, 6'd0, 7'd0, 6'd0);
        queue_conv(64'hDEAD_BEEF, 1'b0, BASE_HEX_LO, F_ALT, 7'd20, 6'd0);
        queue_conv(64'hDEAD_BEEF, 1'b0, BASE_HEX_UP, F_ALT | F_ZERO, 7'd20, 6'd0);
        queue_conv(64'd0, 1'b0, BASE_HEX_LO, F_ALT, 7'd5, 6'd0);
        queue_conv(64'd42, 1'b1, BASE_DEC, F_PLUS, 7'd0, 6'd0);
        queue_conv(64'd42, 1'b1, BASE_DEC, F_SPACE, 7'd6, 6'd0);
        queue_conv(64'd0, 1'b1, BASE_DEC, F_PLUS | F_SPACE, 7'd0, 6'd0);
        queue_conv(64'd42, 1'b0, BASE_DEC, F_PLUS | F_SPACE, 7'd0, 6'd0);
        queue_conv(64'd12345, 1'b1, BASE_DEC, F_LEFT, 7'd30, 6'd0);
        queue_conv(-64'd77, 1'b1, BASE_DEC, F_LEFT | F_ZERO, 7'd12, 6'd0);
        queue_conv(64'd0, 1'b0, BASE_DEC, F_PREC, 7'd0, 6'd0);
        queue_conv(64'd0, 1'b1, BASE_HEX_UP, F_PREC | F_ALT, 7'd10, 6'd0);
        queue_conv(64'd123, 1'b1, BASE_DEC, F_PREC | F_ZERO | F_PLUS, 7'd64, 6'd40);
        queue_conv(64'hABC, 1'b0, BASE_HEX_LO, 6'd0, 7'd127, 6'd0);
        queue_conv(64'd9, 1'b0, BASE_DEC, F_PREC, 7'd0, 6'd63);
        queue_conv(64'd7, 1'b0, BASE_OCT, F_ALT | F_PREC, 7'd0, 6'd5);
        queue_conv(64'd0, 1'b0, BASE_OCT, F_ALT, 7'd0, 6'd0);
        queue_conv(-64'd255, 1'b1, BASE_HEX_UP, F_ZERO | F_PREC | F_ALT, 7'd25, 6'd3);
        queue_conv(64'd5, 1'b0, BASE_DEC, F_PREC, 7'd3, 6'd0);
        queue_conv(-64'd31, 1'b1, BASE_DEC, F_LEFT | F_PREC | F_SPACE, 7'd50, 6'd30);

        // sender pause: let every directed result come out
        while (n_accepted != n_queued || expected_chars.size() != 0) @(posedge i_clk);

        for (int i = 0; i < N_RANDOM; i++) request_q.push_back(random_conv());
        n_queued += N_RANDOM;

        // long receiver hold-off while requests keep coming
        while (n_accepted < 120) @(posedge i_clk);
        want_hold = 1'b1;

        // last stretch runs without idling
        while (n_accepted + QUIET_TAIL < n_queued) @(posedge i_clk);
        quiet = 1'b1;

        while (n_accepted != n_queued || expected_chars.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        if (err_cnt == 0 && expected_chars.size() == 0) begin
            $display("printf_integer_formatter_unit regression: pass");
        end else begin
            $display("printf_integer_formatter_unit regression: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #3_000_000;
        $display("printf_integer_formatter_unit regression: fail");
        $finish;
    end

endmodule
